FILE: hdl/srp_pkg.sv
`timescale 1ns / 1ps

package srp_pkg;

    localparam int DIM_W      = 13;
    localparam int SUM_W      = 15;
    localparam int IDX_W      = 4;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 32;
    localparam int ADDR_W     = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DIM_W-1:0] PAD       = 13'd1;
    localparam logic [DIM_W-1:0] RESET_DIM = 13'd1024;

    localparam logic REG_PAGE_WIDTH  = 1'b0;
    localparam logic REG_PAGE_HEIGHT = 1'b1;

    typedef logic [DIM_W-1:0] dim_t;

    typedef struct packed {
        logic             page_opened;
        dim_t             y_pos;
        dim_t             x_pos;
        logic [IDX_W-1:0] page_index;
        logic             placed;
    } result_t;

endpackage

FILE: hdl/shelf_rect_packer_top.sv
`timescale 1ns / 1ps
// Input register, then result register; throughput is one rectangle per cycle unless
// m_tready stalls the result stream; the placement compare/add logic sits in one stage
// and the shelf state is updated in the same cycle as the result is captured.
// Reset: rst_n asynchronous, active low; page size returns to 1024 x 1024,
// the shelf cursor to (1,1), no pages open, both pipeline stages empty.

module shelf_rect_packer_top
    import srp_pkg::*;
#(
    parameter int MAX_PAGES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // rect_width[12:0], rect_height[25:13], zeros
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata    // placed[0], page_index[4:1], x_pos[17:5],
                                             // y_pos[30:18], page_opened[31]
);

    localparam int PG_W = $clog2(MAX_PAGES + 1);
    localparam int IW   = (PG_W > IDX_W) ? PG_W : IDX_W;
    localparam logic [PG_W-1:0] MAX_PG = PG_W'(MAX_PAGES);

    // configuration
    dim_t page_width_reg;
    dim_t page_height_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_width_reg  <= RESET_DIM;
            page_height_reg <= RESET_DIM;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_PAGE_WIDTH:  page_width_reg  <= pwdata[DIM_W-1:0];
                REG_PAGE_HEIGHT: page_height_reg <= pwdata[DIM_W-1:0];
                default:         page_width_reg  <= page_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PAGE_WIDTH:  prdata = {{(APB_DATA_W-DIM_W){1'b0}}, page_width_reg};
            REG_PAGE_HEIGHT: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, page_height_reg};
            default:         prdata = '0;
        endcase
    end

    // input stage
    logic in_valid_reg;
    dim_t in_w_reg;
    dim_t in_h_reg;
    logic out_valid_reg;
    result_t out_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_w_reg <= s_tdata[DIM_W-1:0];
            in_h_reg <= s_tdata[2*DIM_W-1:DIM_W];
        end
    end

    // shelf state
    dim_t cursor_x_reg, cursor_x_next;
    dim_t shelf_top_reg, shelf_top_next;
    dim_t shelf_height_reg, shelf_height_next;
    logic [PG_W-1:0] pages_used_reg, pages_used_next;

    logic            empty, too_large, first;
    dim_t            cx_e, top_e, sh_e;
    logic [PG_W-1:0] pg_e;
    logic            wrap, fit;
    dim_t            cx1, sh1;
    logic [SUM_W-1:0] top1;
    logic [SUM_W-1:0] end_x;
    logic [IW-1:0]   idx_wide;
    result_t         res;

    always_comb
    begin
        empty     = (in_w_reg == '0) || (in_h_reg == '0);
        too_large = !empty &&
                    ((SUM_W'(in_w_reg) + SUM_W'(2) > SUM_W'(page_width_reg)) ||
                     (SUM_W'(in_h_reg) + SUM_W'(2) > SUM_W'(page_height_reg)));
        first     = (pages_used_reg == '0);

        cx_e  = first ? PAD : cursor_x_reg;
        top_e = first ? PAD : shelf_top_reg;
        sh_e  = first ? '0  : shelf_height_reg;
        pg_e  = first ? PG_W'(1) : pages_used_reg;

        wrap  = SUM_W'(cx_e) + SUM_W'(in_w_reg) + SUM_W'(PAD) > SUM_W'(page_width_reg);
        cx1   = wrap ? PAD : cx_e;
        top1  = wrap ? SUM_W'(top_e) + SUM_W'(sh_e) + SUM_W'(PAD) : SUM_W'(top_e);
        sh1   = wrap ? '0 : sh_e;
        fit   = top1 + SUM_W'(in_h_reg) + SUM_W'(PAD) <= SUM_W'(page_height_reg);
        end_x = SUM_W'(cx1) + SUM_W'(in_w_reg) + SUM_W'(PAD);

        cursor_x_next     = cursor_x_reg;
        shelf_top_next    = shelf_top_reg;
        shelf_height_next = shelf_height_reg;
        pages_used_next   = pages_used_reg;
        res               = '0;

        if (!too_large)
        begin
            cursor_x_next     = cx_e;
            shelf_top_next    = top_e;
            shelf_height_next = sh_e;
            pages_used_next   = pg_e;
            res.page_opened   = first;
            if (empty)
            begin
                res.placed = 1'b1;
                res.x_pos  = cx_e;
                res.y_pos  = top_e;
            end
            else if (fit)
            begin
                res.placed        = 1'b1;
                res.x_pos         = cx1;
                res.y_pos         = top1[DIM_W-1:0];
                cursor_x_next     = end_x[DIM_W-1:0];
                shelf_top_next    = top1[DIM_W-1:0];
                shelf_height_next = (in_h_reg > sh1) ? in_h_reg : sh1;
            end
            else if (pg_e < MAX_PG)
            begin
                // fresh page always fits a rectangle that passed the size check
                res.placed        = 1'b1;
                res.page_opened   = 1'b1;
                res.x_pos         = PAD;
                res.y_pos         = PAD;
                cursor_x_next     = in_w_reg + PAD + PAD;
                shelf_top_next    = PAD;
                shelf_height_next = in_h_reg;
                pages_used_next   = pg_e + PG_W'(1);
            end
            else
            begin
                res.page_opened = 1'b0;
            end
        end

        idx_wide = IW'(pages_used_next) - IW'(1);
        if (res.placed)
            res.page_index = idx_wide[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg     <= PAD;
            shelf_top_reg    <= PAD;
            shelf_height_reg <= '0;
            pages_used_reg   <= '0;
        end
        else if (advance)
        begin
            cursor_x_reg     <= cursor_x_next;
            shelf_top_reg    <= shelf_top_next;
            shelf_height_reg <= shelf_height_next;
            pages_used_reg   <= pages_used_next;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // checks
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.placed |->
            out_reg.page_index == '0 && out_reg.x_pos == '0 &&
            out_reg.y_pos == '0 && !out_reg.page_opened)
        else $error("refused result carries nonzero fields");

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_used_reg <= MAX_PG)
        else $error("page count above limit");

    a_page_open_after: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !too_large |=> pages_used_reg != '0)
        else $error("no page open after a request");

    a_placed_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.placed |-> out_reg.x_pos != '0 && out_reg.y_pos != '0)
        else $error("placement at the padding border");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srp_pkg::*;

    localparam int PAGE_LIMIT    = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int unsigned DIM_MASK = (1 << DIM_W) - 1;

    typedef struct {
        dim_t w;
        dim_t h;
    } rect_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    rect_t   rect_queue[$];
    result_t placement_q[$];
    rect_t   offered;
    result_t got_res;
    result_t want_res;
    int      errors     = 0;
    int      send_gap   = 0;
    int      stall_left = 0;
    int      quiet      = 0;
    bit      send_idle    = 1'b1;
    bit      recv_idle    = 1'b1;
    bit      hold_request = 1'b0;
    bit      hold_done    = 1'b0;

    // mirror of the packer state and page size
    int unsigned page_w     = 32'(RESET_DIM);
    int unsigned page_h     = 32'(RESET_DIM);
    int unsigned cur_x      = 32'(PAD);
    int unsigned shelf_y    = 32'(PAD);
    int unsigned shelf_h    = 0;
    int unsigned pages_open = 0;

    shelf_rect_packer_top #(.MAX_PAGES(PAGE_LIMIT)) DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    function automatic void open_page();
        cur_x   = 32'(PAD);
        shelf_y = 32'(PAD);
        shelf_h = 0;
        if (pages_open < PAGE_LIMIT)
            pages_open++;
    endfunction

    function automatic bit fit_on_page(int unsigned w, int unsigned h,
                                       output int unsigned x, output int unsigned y);
        int unsigned cx;
        int unsigned top;
        int unsigned sh;
        cx  = cur_x;
        top = shelf_y;
        sh  = shelf_h;
        if (cx + w + PAD > page_w)
        begin
            top = top + sh + PAD;
            cx  = PAD;
            sh  = 0;
        end
        if (top + h + PAD > page_h)
            return 1'b0;
        x       = cx;
        y       = top;
        cur_x   = (cx + w + PAD) & DIM_MASK;
        shelf_y = top & DIM_MASK;
        shelf_h = (h > sh) ? h : sh;
        return 1'b1;
    endfunction

    function automatic result_t place_rect(rect_t r);
        result_t     res;
        int unsigned x;
        int unsigned y;
        bit          opened;
        bit          ok;
        res    = '0;
        x      = 0;
        y      = 0;
        opened = 1'b0;
        if (r.w != 0 && r.h != 0 && (r.w + 2 * PAD > page_w || r.h + 2 * PAD > page_h))
            return res;
        if (pages_open == 0)
        begin
            open_page();
            opened = 1'b1;
        end
        if (r.w == 0 || r.h == 0)
        begin
            x  = cur_x;
            y  = shelf_y;
            ok = 1'b1;
        end
        else
        begin
            ok = fit_on_page(32'(r.w), 32'(r.h), x, y);
            if (!ok && pages_open < PAGE_LIMIT)
            begin
                open_page();
                opened = 1'b1;
                ok     = fit_on_page(32'(r.w), 32'(r.h), x, y);
            end
        end
        if (!ok)
            return res;
        res.placed      = 1'b1;
        res.page_index  = IDX_W'(pages_open - 1);
        res.x_pos       = DIM_W'(x);
        res.y_pos       = DIM_W'(y);
        res.page_opened = opened;
        return res;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                placement_q.push_back(place_rect(offered));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (rect_queue.size() != 0)
                begin
                    offered = rect_queue.pop_front();
                    s_tdata <= {{(S_DATA_W - 2 * DIM_W){1'b0}}, offered.h, offered.w};
                    s_tvalid <= 1'b1;
                    if (send_idle && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 6);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_res = result_t'(m_tdata);
                if (placement_q.size() == 0)
                    report_mismatch("unsolicited result", m_tdata, 0);
                else
                begin
                    want_res = placement_q.pop_front();
                    if (got_res.placed !== want_res.placed)
                        report_mismatch("placed", 32'(got_res.placed),
                                        32'(want_res.placed));
                    if (got_res.page_index !== want_res.page_index)
                        report_mismatch("page_index", 32'(got_res.page_index),
                                        32'(want_res.page_index));
                    if (got_res.x_pos !== want_res.x_pos)
                        report_mismatch("x_pos", 32'(got_res.x_pos), 32'(want_res.x_pos));
                    if (got_res.y_pos !== want_res.y_pos)
                        report_mismatch("y_pos", 32'(got_res.y_pos), 32'(want_res.y_pos));
                    if (got_res.page_opened !== want_res.page_opened)
                        report_mismatch("page_opened", 32'(got_res.page_opened),
                                        32'(want_res.page_opened));
                end
            end
            if (hold_request && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (recv_idle && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("FAIL shelf_rect_packer_top");
                $finish;
            end
        end
    end

    task automatic write_reg(logic idx, int unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & DIM_MASK) !== (value & DIM_MASK))
            report_mismatch("register readback", prdata, value & DIM_MASK);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_PAGE_WIDTH)
            page_w = value & DIM_MASK;
        else
            page_h = value & DIM_MASK;
    endtask

    task automatic queue_rect(int unsigned w, int unsigned h);
        rect_t r;
        r.w = DIM_W'(w);
        r.h = DIM_W'(h);
        rect_queue.push_back(r);
    endtask

    task automatic queue_random(int unsigned pw, int unsigned ph, int unsigned wdiv,
                                int unsigned hdiv, int count);
        int unsigned k;
        int unsigned lo;
        repeat (count)
        begin
            k = $urandom_range(0, 19);
            if (k == 0)
                queue_rect(0, $urandom_range(0, 4096));
            else if (k == 1)
                queue_rect($urandom_range(0, 4096), 0);
            else if (k == 2)
            begin
                lo = (pw > 2) ? pw - 1 : 1;
                queue_rect($urandom_range(lo, 4096), $urandom_range(1, 4096));
            end
            else
                queue_rect($urandom_range(1, (pw / wdiv > 1) ? pw / wdiv : 1),
                           $urandom_range(1, (ph / hdiv > 1) ? ph / hdiv : 1));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (rect_queue.size() != 0 || s_tvalid || placement_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned pw;
        int unsigned ph;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset page size: first request, exact fits, shelf wrap, page turn
        queue_rect(0, 0);
        queue_rect(4096, 4096);
        queue_rect(1023, 10);
        queue_rect(1022, 10);
        queue_rect(5, 0);
        queue_rect(1, 1);
        queue_rect(0, 7);
        queue_rect(1, 1022);
        queue_rect(4096, 0);
        queue_rect(0, 4096);
        queue_rect(1, 1);
        queue_rect(8, 1);
        drain();

        write_reg(REG_PAGE_WIDTH, 4096);
        write_reg(REG_PAGE_HEIGHT, 4096);
        queue_rect(4094, 4094);
        queue_rect(4095, 1);
        queue_rect(1, 4095);
        queue_rect(1, 1);
        drain();

        write_reg(REG_PAGE_WIDTH, 1);
        write_reg(REG_PAGE_HEIGHT, 1);
        queue_rect(1, 1);
        queue_rect(0, 3);
        queue_rect(3, 0);
        drain();

        // zero page size
        write_reg(REG_PAGE_WIDTH, 0);
        queue_rect(1, 1);
        queue_rect(0, 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if (p < 6)
            begin
                pw = $urandom_range(48, 1024);
                ph = $urandom_range(48, 1024);
            end
            else if (p == 6)
            begin
                pw = 16;
                ph = 24;
            end
            else
            begin
                pw = 4096;
                ph = 4096;
            end
            write_reg(REG_PAGE_WIDTH, pw);
            write_reg(REG_PAGE_HEIGHT, ph);
            send_idle    = (p == 0) || ($urandom_range(0, 3) != 0);
            recv_idle    = (p == 0) || ($urandom_range(0, 3) != 0);
            hold_request = (p == 0);
            if (p == 7)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
                queue_random(pw, ph, 16, 16, 120);
            end
            else if (p == 6)
                queue_random(pw, ph, 2, 2, 110);
            else
                queue_random(pw, ph, 6, 8, 110);
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS shelf_rect_packer_top");
        else
            $display("FAIL shelf_rect_packer_top");
        $finish;
    end

endmodule
